/* rtl/srrw_pkg.sv */
// Shared types and constants for the selective-repeat receive window.
`default_nettype none

package srrw_pkg;

    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    localparam logic REG_WINDOW_SIZE       = 1'b0;
    localparam logic REG_EXPECTED_PROTOCOL = 1'b1;

    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned WIN_W   = 6;
    localparam int unsigned CFG_W   = 16;

    typedef struct packed {
        logic load;
        logic eval;
        logic mark;
        logic rd;
        logic emit_seg;
        logic emit_ack;
    } srrw_cmd_t;

    typedef struct packed {
        logic is_timeout;
        logic tag_bad;
        logic old;
        logic beyond;
        logic dup;
        logic walk_more;
        logic out_free;
    } srrw_sts_t;

endpackage

`default_nettype wire

/* rtl/srrw_ctrl.sv */
// Controller state machine that sequences checks, marking and the release walk.
`default_nettype none

module srrw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire srrw_pkg::srrw_sts_t sts,
    output srrw_pkg::srrw_cmd_t     cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EVAL   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_MARK   = 7'b0001000,
        S_WALK   = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_ACK    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.is_timeout)
                begin
                    state_next = S_ACK;
                end
                else if (sts.tag_bad)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.old)
                begin
                    state_next = S_ACK;
                end
                else if (sts.beyond || sts.dup)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (sts.walk_more)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_seg = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/srrw_dp.sv */
// Datapath: window state, receive bitmap, length memory and output register.
`default_nettype none

module srrw_dp #(
    parameter int WINDOW_MAX  = 32,
    parameter int MAX_SEGMENT = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          command,
    input  wire logic [srrw_pkg::TAG_W-1:0]    protocol_tag,
    input  wire logic [srrw_pkg::SEQ_W-1:0]    seq_number,
    input  wire logic [srrw_pkg::LEN_W-1:0]    payload_len,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [srrw_pkg::CFG_W-1:0]    cfg_data,
    input  wire srrw_pkg::srrw_cmd_t           cmd,
    output srrw_pkg::srrw_sts_t                sts,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               result_kind,
    output logic [srrw_pkg::SEQ_W-1:0]         number_out,
    output logic [srrw_pkg::LEN_W-1:0]         released_len,
    output logic [srrw_pkg::SEQ_W-1:0]         bytes_delivered,
    output logic                               last_of_run
);

    localparam int DEPTH = WINDOW_MAX + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int SW    = $clog2(DEPTH + 1);

    logic                        cmd_reg;
    logic [srrw_pkg::TAG_W-1:0]  tag_reg;
    logic [srrw_pkg::SEQ_W-1:0]  seq_reg;
    logic [srrw_pkg::LEN_W-1:0]  len_reg;

    logic [srrw_pkg::WIN_W-1:0]  window_reg;
    logic [srrw_pkg::TAG_W-1:0]  proto_reg;

    logic [srrw_pkg::SEQ_W-1:0]  expected_reg;
    logic [srrw_pkg::SEQ_W-1:0]  total_reg;
    logic [srrw_pkg::SEQ_W-1:0]  offset_reg;
    logic                        old_reg;
    logic [IW-1:0]               head_reg;
    logic [SW-1:0]               cnt_reg;
    logic [DEPTH-1:0]            map_reg;

    logic [srrw_pkg::LEN_W-1:0]  len_mem [DEPTH];
    logic [srrw_pkg::LEN_W-1:0]  rd_data_reg;

    logic                        out_valid_reg;
    logic                        kind_reg;
    logic [srrw_pkg::SEQ_W-1:0]  number_reg;
    logic [srrw_pkg::LEN_W-1:0]  rel_len_reg;
    logic [srrw_pkg::SEQ_W-1:0]  bytes_reg;
    logic                        last_reg;

    logic [srrw_pkg::WIN_W-1:0]  win_clamp;
    logic [SW-1:0]               span;
    logic [IW:0]                 idx_sum;
    logic [IW-1:0]               idx;
    logic [IW-1:0]               head_inc;
    logic [srrw_pkg::LEN_W-1:0]  sat_len;
    logic [srrw_pkg::SEQ_W-1:0]  total_sum;

    always_comb
    begin
        if (window_reg == '0)
        begin
            win_clamp = srrw_pkg::WIN_W'(1);
        end
        else if (window_reg > srrw_pkg::WIN_W'(WINDOW_MAX))
        begin
            win_clamp = srrw_pkg::WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_clamp = window_reg;
        end
        span = SW'(win_clamp) + SW'(1);

        idx_sum = {1'b0, head_reg} + {1'b0, offset_reg[IW-1:0]};
        if (idx_sum >= (IW + 1)'(DEPTH))
        begin
            idx = IW'(idx_sum - (IW + 1)'(DEPTH));
        end
        else
        begin
            idx = idx_sum[IW-1:0];
        end

        head_inc = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);

        if (32'(len_reg) > 32'(MAX_SEGMENT))
        begin
            sat_len = srrw_pkg::LEN_W'(MAX_SEGMENT);
        end
        else
        begin
            sat_len = len_reg;
        end

        total_sum = total_reg + srrw_pkg::SEQ_W'(rd_data_reg);
    end

    assign sts.is_timeout = (cmd_reg == srrw_pkg::CMD_TIMEOUT);
    assign sts.tag_bad    = (tag_reg != proto_reg);
    assign sts.old        = old_reg;
    assign sts.beyond     = (offset_reg >= srrw_pkg::SEQ_W'(span));
    assign sts.dup        = map_reg[idx];
    assign sts.walk_more  = map_reg[head_reg] && (cnt_reg < span);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            tag_reg <= protocol_tag;
            seq_reg <= seq_number;
            len_reg <= payload_len;
        end
        if (cmd.eval)
        begin
            offset_reg <= seq_reg - expected_reg;
            old_reg    <= (seq_reg < expected_reg);
        end
        if (cmd.mark)
        begin
            len_mem[idx] <= sat_len;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= len_mem[head_reg];
        end
        if (cmd.emit_seg)
        begin
            kind_reg    <= srrw_pkg::KIND_RELEASE;
            number_reg  <= expected_reg;
            rel_len_reg <= rd_data_reg;
            bytes_reg   <= total_sum;
            last_reg    <= 1'b0;
        end
        else if (cmd.emit_ack)
        begin
            kind_reg    <= srrw_pkg::KIND_ACK;
            number_reg  <= expected_reg - srrw_pkg::SEQ_W'(1);
            rel_len_reg <= '0;
            bytes_reg   <= total_reg;
            last_reg    <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= srrw_pkg::WIN_W'(32);
            proto_reg     <= '0;
            expected_reg  <= srrw_pkg::SEQ_W'(1);
            total_reg     <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    srrw_pkg::REG_WINDOW_SIZE:
                    begin
                        window_reg <= cfg_data[srrw_pkg::WIN_W-1:0];
                    end
                    srrw_pkg::REG_EXPECTED_PROTOCOL:
                    begin
                        proto_reg <= cfg_data;
                    end
                    default:
                    begin
                        proto_reg <= proto_reg;
                    end
                endcase
            end
            if (cmd.mark)
            begin
                map_reg[idx] <= 1'b1;
                cnt_reg      <= '0;
            end
            if (cmd.emit_seg)
            begin
                map_reg[head_reg] <= 1'b0;
                head_reg          <= head_inc;
                expected_reg      <= expected_reg + srrw_pkg::SEQ_W'(1);
                total_reg         <= total_sum;
                cnt_reg           <= cnt_reg + SW'(1);
            end
            if (cmd.emit_seg || cmd.emit_ack)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign number_out      = number_reg;
    assign released_len    = rel_len_reg;
    assign bytes_delivered = bytes_reg;
    assign last_of_run     = last_reg;

endmodule

`default_nettype wire

/* rtl/selective_repeat_receive_window_top.sv */
// Top level of the selective-repeat receive window: controller plus datapath.
`default_nettype none

// Receiver side of a selective-repeat link for one connection. One input beat is
// worked on at a time. A timeout tick or an old segment goes from load through
// evaluate and decide to its ack; a dropped segment returns to idle with no result.
// An accepted segment is marked, then the release walk reads, in order, one stored
// length at a time from the single-port length memory and emits it. Results leave
// through an output register, so the next beat is taken while the last result waits.
module selective_repeat_receive_window_top #(
    parameter int WINDOW_MAX  = 32,
    parameter int MAX_SEGMENT = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          command,
    input  wire logic [srrw_pkg::TAG_W-1:0]    protocol_tag,
    input  wire logic [srrw_pkg::SEQ_W-1:0]    seq_number,
    input  wire logic [srrw_pkg::LEN_W-1:0]    payload_len,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [srrw_pkg::CFG_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               result_kind,
    output logic [srrw_pkg::SEQ_W-1:0]         number_out,
    output logic [srrw_pkg::LEN_W-1:0]         released_len,
    output logic [srrw_pkg::SEQ_W-1:0]         bytes_delivered,
    output logic                               last_of_run
);

    srrw_pkg::srrw_cmd_t cmd;
    srrw_pkg::srrw_sts_t sts;

    srrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    srrw_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .MAX_SEGMENT (MAX_SEGMENT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .protocol_tag    (protocol_tag),
        .seq_number      (seq_number),
        .payload_len     (payload_len),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .number_out      (number_out),
        .released_len    (released_len),
        .bytes_delivered (bytes_delivered),
        .last_of_run     (last_of_run)
    );

endmodule

`default_nettype wire
